/* sv/ftpbs_pkg.sv */
// ----------------------------------------------------------------------------
// ftpbs_pkg
// shared types and codes for the two pass box smoother
// ----------------------------------------------------------------------------
package ftpbs_pkg;

  typedef enum logic [1:0] {
    FuncWrite  = 2'd0,
    FuncSmooth = 2'd1,
    FuncRead   = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StReadResp,
    StRdTop0,
    StRdBot0,
    StRdTopN,
    StRdBotN,
    StWrite
  } state_e;

  localparam logic CfgFrameWidth  = 1'b0;
  localparam logic CfgFrameHeight = 1'b1;

  function automatic logic [7:0] avg4(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c, input logic [7:0] d);
    logic [9:0] sum;
    sum = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
    return sum[9:2];
  endfunction

endpackage

/* sv/frame_two_pass_box_smoother.sv */
// ----------------------------------------------------------------------------
// frame_two_pass_box_smoother
// byte frame store with cell write, cell read and a two pass 2x2 box smoothing
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------
//  in       | in_valid_i / in_stall_o | func_i row_index_i col_index_i cell_value_i
//  out      | out_valid_o / out_stall_i | read_value_o
//  cfg      | cfg_we_i                | cfg_index_i cfg_wdata_i
//
//  write item: result registered from idle, read item: result registered in StReadResp (one frame memory read port)
//  smoothing item: two reads per cell on the port
//  after reset a clearing pass writes zero to every cell of the frame
//  in_stall_o is high while busy or while a result waits in the output register
// ----------------------------------------------------------------------------
module frame_two_pass_box_smoother import ftpbs_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] func_i,
  input  logic [6:0] row_index_i,
  input  logic [7:0] col_index_i,
  input  logic [7:0] cell_value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_value_o,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [8:0] cfg_wdata_i
);

  localparam int Depth = MAX_HEIGHT * MAX_WIDTH;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam logic [AW-1:0] RowStep  = AW'(MAX_WIDTH);
  localparam logic [AW-1:0] LastAddr = AW'(Depth - 1);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata;

  state_e state_q, state_d;
  logic [8:0] frame_width_q;
  logic [7:0] frame_height_q;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] base_q, base_d;
  logic [CW-1:0] col_q, col_d, col_n;
  logic [RW-1:0] row_q, row_d;
  logic pass_q, pass_d;
  logic in_frame_q, in_frame_d;
  logic [7:0] cur_top_q, cur_top_d, cur_bot_q, cur_bot_d, nxt_top_q, nxt_top_d;
  logic out_valid_q, out_valid_d;
  logic [7:0] read_value_q, read_value_d;

  logic [CW-1:0] w_last;
  logic [RW-1:0] h_last;
  logic in_accept, out_free, in_frame;
  logic [AW-1:0] host_addr;
  func_e func;

  always_comb begin
    if (frame_width_q < 9'd2) begin
      w_last = CW'(1);
    end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(frame_width_q - 9'd1);
    end
    if (frame_height_q < 8'd2) begin
      h_last = '0;
    end else if (32'(frame_height_q) > 32'(MAX_HEIGHT)) begin
      h_last = RW'(MAX_HEIGHT - 2);
    end else begin
      h_last = RW'(frame_height_q - 8'd2);
    end
  end

  assign func      = func_e'(func_i);
  assign in_frame  = (32'(row_index_i) < 32'(MAX_HEIGHT)) &&
                     (32'(col_index_i) < 32'(MAX_WIDTH));
  assign host_addr = AW'(row_index_i) * RowStep + AW'(col_index_i);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == StIdle) && out_free);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign col_n      = pass_q ? (col_q - CW'(1)) : (col_q + CW'(1));

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    base_d       = base_q;
    col_d        = col_q;
    row_d        = row_q;
    pass_d       = pass_q;
    in_frame_d   = in_frame_q;
    cur_top_d    = cur_top_q;
    cur_bot_d    = cur_bot_q;
    nxt_top_d    = nxt_top_q;
    out_valid_d  = out_valid_q && out_stall_i;
    read_value_d = read_value_q;
    mem_we       = 1'b0;
    mem_waddr    = base_q + AW'(col_q);
    mem_wdata    = avg4(cur_top_q, cur_bot_q, nxt_top_q, rdata_q);
    mem_raddr    = host_addr;
    case (state_q)
      StClear: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == LastAddr) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_accept) begin
          case (func)
            FuncWrite: begin
              mem_we       = in_frame;
              mem_waddr    = host_addr;
              mem_wdata    = cell_value_i;
              out_valid_d  = 1'b1;
              read_value_d = '0;
            end
            FuncSmooth: begin
              base_d  = '0;
              col_d   = '0;
              row_d   = '0;
              pass_d  = 1'b0;
              state_d = StRdTop0;
            end
            FuncRead: begin
              in_frame_d = in_frame;
              state_d    = StReadResp;
            end
            default: begin
              out_valid_d  = 1'b1;
              read_value_d = '0;
            end
          endcase
        end
      end
      StReadResp: begin
        out_valid_d  = 1'b1;
        read_value_d = in_frame_q ? rdata_q : '0;
        state_d      = StIdle;
      end
      StRdTop0: begin
        mem_raddr = base_q + AW'(col_q);
        state_d   = StRdBot0;
      end
      StRdBot0: begin
        mem_raddr = base_q + RowStep + AW'(col_q);
        cur_top_d = rdata_q;
        state_d   = StRdTopN;
      end
      StRdTopN: begin
        mem_raddr = base_q + AW'(col_n);
        cur_bot_d = rdata_q;
        state_d   = StRdBotN;
      end
      StRdBotN: begin
        mem_raddr = base_q + RowStep + AW'(col_n);
        nxt_top_d = rdata_q;
        state_d   = StWrite;
      end
      StWrite: begin
        mem_we    = 1'b1;
        cur_top_d = nxt_top_q;
        cur_bot_d = rdata_q;
        col_d     = col_n;
        mem_raddr = base_q + AW'(pass_q ? (col_n - CW'(1)) : (col_n + CW'(1)));
        state_d   = StRdBotN;
        if (pass_q ? (col_n == '0) : (col_n == w_last)) begin
          state_d = StRdTop0;
          if (row_q == h_last) begin
            row_d  = '0;
            base_d = '0;
            col_d  = w_last;
            pass_d = 1'b1;
            if (pass_q) begin
              out_valid_d  = 1'b1;
              read_value_d = '0;
              state_d      = StIdle;
            end
          end else begin
            row_d  = row_q + RW'(1);
            base_d = base_q + RowStep;
            col_d  = pass_q ? w_last : '0;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // frame memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      base_q      <= '0;
      col_q       <= '0;
      row_q       <= '0;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      base_q      <= base_d;
      col_q       <= col_d;
      row_q       <= row_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= 9'd256;
      frame_height_q <= 8'd128;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgFrameWidth:  frame_width_q  <= cfg_wdata_i;
        CfgFrameHeight: frame_height_q <= cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    in_frame_q   <= in_frame_d;
    cur_top_q    <= cur_top_d;
    cur_bot_q    <= cur_bot_d;
    nxt_top_q    <= nxt_top_d;
    read_value_q <= read_value_d;
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;

endmodule

/* verif/smoother_frame_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smoother_frame_checker
// Watches the item, result and register ports of the two pass box smoother.
// Keeps its own copy of the frame and of the frame size registers, works out
// the read value due for every accepted item, and compares each accepted
// result with the oldest value due. Failures are counted for the test top.
// ----------------------------------------------------------------------------
module smoother_frame_checker import ftpbs_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [1:0] func_i,
  input  logic [6:0] row_index_i,
  input  logic [7:0] col_index_i,
  input  logic [7:0] cell_value_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] read_value_i,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [8:0] cfg_wdata_i,
  output int         error_count_o,
  output int         pending_o
);

  localparam int DueDepth = 8;
  localparam int DuePtrW  = $clog2(DueDepth);

  logic [7:0] frame_copy [MAX_HEIGHT][MAX_WIDTH];
  logic [8:0] width_reg;
  logic [7:0] height_reg;
  logic [7:0] due_fifo [DueDepth];
  logic [DuePtrW-1:0] due_rd;
  logic [DuePtrW-1:0] due_wr;
  int due_count;

  function automatic int clamp_extent(int v, int hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic smooth_frame_copy();
    int cols;
    int rows;
    int sum;
    int r;
    int x;
    cols = clamp_extent(int'(width_reg), MAX_WIDTH);
    rows = clamp_extent(int'(height_reg), MAX_HEIGHT);
    // left to right, window to the right and below
    for (r = 0; r < rows - 1; r++) begin
      for (x = 0; x < cols - 1; x++) begin
        sum = frame_copy[r][x] + frame_copy[r+1][x] + frame_copy[r][x+1] + frame_copy[r+1][x+1];
        frame_copy[r][x] = 8'(sum >> 2);
      end
    end
    // right to left, window to the left and below
    for (r = 0; r < rows - 1; r++) begin
      for (x = cols - 1; x > 0; x--) begin
        sum = frame_copy[r][x] + frame_copy[r+1][x] + frame_copy[r][x-1] + frame_copy[r+1][x-1];
        frame_copy[r][x] = 8'(sum >> 2);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [7:0] due;
    if (!rst_ni) begin
      foreach (frame_copy[r, x]) frame_copy[r][x] = '0;
      width_reg = 9'd256;
      height_reg = 8'd128;
      due_rd = '0;
      due_wr = '0;
      due_count = 0;
      error_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_count == 0) begin
          error_count_o++;
          $display("%0t unexpected result: expected none actual %0d", $time, read_value_i);
        end else begin
          due = due_fifo[due_rd];
          due_rd = due_rd + DuePtrW'(1);
          due_count--;
          if (read_value_i !== due) begin
            error_count_o++;
            $display("%0t read_value mismatch: expected %0d actual %0d",
                     $time, due, read_value_i);
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CfgFrameWidth) width_reg = cfg_wdata_i;
        else height_reg = cfg_wdata_i[7:0];
      end
      if (in_valid_i && !in_stall_i) begin
        due = '0;
        case (func_i)
          FuncWrite:  frame_copy[row_index_i][col_index_i] = cell_value_i;
          FuncSmooth: smooth_frame_copy();
          FuncRead:   due = frame_copy[row_index_i][col_index_i];
          default:    ;
        endcase
        if (due_count == DueDepth) begin
          error_count_o++;
          $display("%0t too many items in flight: expected at most %0d actual %0d",
                   $time, DueDepth, due_count + 1);
        end else begin
          due_fifo[due_wr] = due;
          due_wr = due_wr + DuePtrW'(1);
          due_count++;
        end
      end
      pending_o = due_count;
    end
  end

endmodule

/* verif/frame_two_pass_box_smoother_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_two_pass_box_smoother_test
// Drives cell writes, cell reads and smoothing steps into the smoother over a
// range of frame sizes, first a short directed set, then random bursts with
// random gaps and a randomly stalling result side, including one long stall.
// Checking is done by the frame checker instantiated beside the block.
// ----------------------------------------------------------------------------
module frame_two_pass_box_smoother_test;
  import ftpbs_pkg::*;

  localparam int FrameCols = 256;
  localparam int FrameRows = 128;
  localparam int CycleLimit = 20_000_000;
  localparam int PhaseCount = 10;
  localparam int ItemsPerPhase = 175;
  localparam logic [1:0] FuncUnused = 2'd3;

  typedef enum int {StallNone, StallLight, StallHeavy, StallPeriodic} stall_mode_e;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] func = FuncWrite;
  logic [6:0] row_index = '0;
  logic [7:0] col_index = '0;
  logic [7:0] cell_value = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] read_value;
  logic       cfg_we = 1'b0;
  logic       cfg_index = CfgFrameWidth;
  logic [8:0] cfg_wdata = '0;

  int fail_count;
  int pending_count;
  int cycle_count = 0;
  int cur_w = FrameCols;
  int cur_h = FrameRows;
  bit hold_off_wanted = 1'b0;
  bit hold_off_done = 1'b0;

  frame_two_pass_box_smoother #(
    .MAX_WIDTH (FrameCols),
    .MAX_HEIGHT(FrameRows)
  ) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .func_i      (func),
    .row_index_i (row_index),
    .col_index_i (col_index),
    .cell_value_i(cell_value),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .read_value_o(read_value),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  smoother_frame_checker #(
    .MAX_WIDTH (FrameCols),
    .MAX_HEIGHT(FrameRows)
  ) checker_inst (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .func_i       (func),
    .row_index_i  (row_index),
    .col_index_i  (col_index),
    .cell_value_i (cell_value),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .read_value_i (read_value),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .error_count_o(fail_count),
    .pending_o    (pending_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side stalls
  initial begin
    stall_mode_e mode;
    int seg_len;
    int tick;
    tick = 0;
    forever begin
      if (hold_off_wanted && !hold_off_done) begin
        hold_off_done = 1'b1;
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (600) @(negedge clk);
      end
      mode = stall_mode_e'($urandom_range(0, 3));
      seg_len = $urandom_range(10, 100);
      repeat (seg_len) begin
        @(negedge clk);
        tick++;
        case (mode)
          StallNone:  out_stall <= 1'b0;
          StallLight: out_stall <= ($urandom_range(0, 3) == 0);
          StallHeavy: out_stall <= ($urandom_range(0, 3) != 0);
          default:    out_stall <= (tick % 3 == 0);
        endcase
      end
    end
  end

  task automatic send_item(logic [1:0] f, logic [6:0] r, logic [7:0] c, logic [7:0] v);
    @(negedge clk);
    in_valid <= 1'b1;
    func <= f;
    row_index <= r;
    col_index <= c;
    cell_value <= v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_gap(int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    func <= 2'($urandom);
    row_index <= 7'($urandom);
    col_index <= 8'($urandom);
    cell_value <= 8'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    @(negedge clk);
    wait (pending_count == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [8:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_index <= 1'($urandom);
    cfg_wdata <= 9'($urandom);
  endtask

  task automatic set_dims(int wr, int hr);
    write_reg(CfgFrameWidth, 9'(wr));
    write_reg(CfgFrameHeight, {1'($urandom_range(0, 1)), 8'(hr)});
    cur_w = (wr < 2) ? 2 : ((wr > FrameCols) ? FrameCols : wr);
    cur_h = (hr < 2) ? 2 : ((hr > FrameRows) ? FrameRows : hr);
  endtask

  initial begin
    int pick;
    int burst_left;
    int gap;
    int wr;
    int hr;
    logic [1:0] f;
    logic [6:0] r;
    logic [7:0] c;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // reset size, cleared frame, corner cells and the unused code
    send_item(FuncRead, 7'd0, 8'd0, 8'h00);
    send_item(FuncRead, 7'd127, 8'd255, 8'hFF);
    send_item(FuncWrite, 7'd0, 8'd0, 8'hFF);
    send_item(FuncWrite, 7'd127, 8'd255, 8'hFF);
    send_item(FuncWrite, 7'd0, 8'd1, 8'h80);
    send_item(FuncWrite, 7'd1, 8'd0, 8'h01);
    send_item(FuncRead, 7'd0, 8'd0, 8'h00);
    send_item(FuncRead, 7'd127, 8'd255, 8'h00);
    send_item(FuncUnused, 7'd5, 8'd5, 8'hAA);
    send_item(FuncRead, 7'd5, 8'd5, 8'h00);
    settle();

    // smallest frame, read outside it too
    set_dims(2, 2);
    send_item(FuncWrite, 7'd0, 8'd0, 8'hFF);
    send_item(FuncWrite, 7'd0, 8'd1, 8'hFF);
    send_item(FuncWrite, 7'd1, 8'd0, 8'hFF);
    send_item(FuncWrite, 7'd1, 8'd1, 8'hFE);
    send_item(FuncSmooth, 7'd0, 8'd0, 8'h00);
    send_item(FuncRead, 7'd0, 8'd0, 8'h00);
    send_item(FuncRead, 7'd0, 8'd1, 8'h00);
    send_item(FuncRead, 7'd1, 8'd1, 8'h00);
    send_item(FuncRead, 7'd0, 8'd2, 8'h00);
    settle();

    // sizes below range saturate low
    set_dims(0, 0);
    send_item(FuncSmooth, 7'd0, 8'd0, 8'h00);
    send_item(FuncRead, 7'd0, 8'd1, 8'h00);
    settle();

    // sizes above range saturate to the full frame
    set_dims(511, 255);
    send_item(FuncSmooth, 7'd0, 8'd0, 8'h00);
    send_item(FuncRead, 7'd0, 8'd255, 8'h00);
    send_item(FuncRead, 7'd126, 8'd0, 8'h00);
    settle();

    burst_left = 0;
    for (int p = 0; p < PhaseCount; p++) begin
      pick = (p < 2) ? p : $urandom_range(0, 9);
      case (pick)
        0: begin wr = FrameCols; hr = 2; end
        1: begin wr = 2; hr = FrameRows; end
        2: begin wr = $urandom_range(257, 511); hr = $urandom_range(0, 1); end
        3: begin wr = $urandom_range(0, 1); hr = $urandom_range(129, 255); end
        default: begin wr = $urandom_range(2, 12); hr = $urandom_range(2, 8); end
      endcase
      set_dims(wr, hr);
      if (p == 2) hold_off_wanted = 1'b1;
      for (int i = 0; i < ItemsPerPhase; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) f = FuncSmooth;
        else if (pick < 13) f = FuncUnused;
        else if (pick < 55) f = FuncWrite;
        else f = FuncRead;
        if ($urandom_range(0, 3) != 0) begin
          r = 7'($urandom_range(0, (cur_h < FrameRows) ? cur_h : FrameRows - 1));
          c = 8'($urandom_range(0, (cur_w < FrameCols) ? cur_w : FrameCols - 1));
        end else begin
          r = 7'($urandom);
          c = 8'($urandom);
        end
        send_item(f, r, c, 8'($urandom));
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
          if (gap > 0) idle_gap(gap);
        end
      end
      settle();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/ftpbs_pkg.sv
sv/frame_two_pass_box_smoother.sv
verif/smoother_frame_checker.sv
verif/frame_two_pass_box_smoother_test.sv
